[src/mpt_pkg.sv]
// Package: shared constants, codes and types of the marker position table.
package mpt_pkg;

    localparam int SLOTS_DEF    = 1024;
    localparam int POS_BITS_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 10;
    localparam int POS_W    = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD         = 3'd0,
        MODE_REMOVE      = 3'd1,
        MODE_SET_POS     = 3'd2,
        MODE_GET_POS     = 3'd3,
        MODE_ADJ_INSERT  = 3'd4,
        MODE_ADJ_REPLACE = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOT_USED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

[src/mpt_req_if.sv]
// Interface: request channel of the marker position table.
interface mpt_req_if
    import mpt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot_index;
    logic                advance_on_insert;
    logic [POS_W-1:0]    first_pos;
    logic [POS_W-1:0]    second_pos;
    logic [POS_W-1:0]    new_length;
    logic                advance_all;

    modport source (
        output valid, mode, slot_index, advance_on_insert, first_pos, second_pos,
               new_length, advance_all,
        input  ready
    );
    modport sink (
        input  valid, mode, slot_index, advance_on_insert, first_pos, second_pos,
               new_length, advance_all,
        output ready
    );
endinterface

[src/mpt_rsp_if.sv]
// Interface: response channel of the marker position table.
interface mpt_rsp_if
    import mpt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   result_slot;
    logic [POS_W-1:0]    result_pos;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, result_slot, result_pos, status,
        input  ready
    );
    modport sink (
        input  valid, result_slot, result_pos, status,
        output ready
    );
endinterface

[src/mpt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module mpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

[src/marker_position_table_core.sv]
// Top level: marker position table with free list and adjust walks.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------------
//  i_req   | in  | valid/ready   | mode, slot_index, advance_on_insert, first_pos,
//          |     |               | second_pos, new_length, advance_all
//  o_rsp   | out | valid/ready   | result_slot, result_pos, status
//
//  Add, remove, set and get run exec on the read data with write back, then hand
//  off through the done state to the response register. Adjust requests stream
//  one slot per cycle through the single read port of the position RAM, from
//  slot 0 up to the highest used slot, then drain the last read.
//  One request is in flight at a time.
//  Reset (synchronous, active low) needs no memory sweep: a fresh-slot mark
//  stands in for the cleared used bits and the initial free links. A stalled
//  response holds in the output register; the block waits in its done state
//  until that register frees up.
module marker_position_table_core
    import mpt_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpt_req_if.sink   i_req,
    mpt_rsp_if.source o_rsp
);
    localparam int IW = $clog2(SLOTS);
    localparam int P  = POS_BITS;
    localparam logic [63:0] POS_MAX = (64'd1 << P) - 64'd1;
    localparam logic [IW:0] SLOTS_END = (IW+1)'(SLOTS);

    // Clamp a 32-bit input position into the internal range.
    function automatic logic [P-1:0] clamp_in(input logic [POS_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        if (w > POS_MAX) begin
            return POS_MAX[P-1:0];
        end
        return w[P-1:0];
    endfunction

    // Add a signed offset to a position, saturate to [0, POS_MAX].
    function automatic logic [P-1:0] add_sat(input logic [P-1:0] c, input logic [P:0] d);
        logic signed [P+1:0] s;
        s = $signed({2'b00, c}) + $signed({d[P], d});
        if (s[P+1]) begin
            return '0;
        end
        if (s[P]) begin
            return POS_MAX[P-1:0];
        end
        return s[P-1:0];
    endfunction

    // ---- control and request registers ----
    t_state            r_state, n_state;
    t_mode             r_mode;
    logic [SLOT_W-1:0] r_slot_in;
    logic [IW-1:0]     r_idx;
    logic              r_idx_ok;
    logic              r_adv, r_before;
    logic [P-1:0]      r_p1, r_p2, r_nl;

    // Table bookkeeping: free-list head, first never-allocated slot, highest slot used.
    logic [IW:0]       r_free_head, n_free_head;
    logic [IW:0]       r_fresh, n_fresh;
    logic [IW-1:0]     r_highest, n_highest;

    // Adjust walk.
    logic [P:0]        r_delta, n_delta;
    logic [P:0]        r_old_end, n_old_end;
    logic [IW-1:0]     r_addr, n_addr;
    logic              r_rd_valid;
    logic [IW-1:0]     r_rd_idx;

    // Finished result and output register.
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    logic [POS_W-1:0]  r_res_pos, n_res_pos;
    t_status           r_res_status, n_res_status;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [POS_W-1:0]  r_out_pos;
    t_status           r_out_status;

    // ---- memories ----
    // flags word: {used, advance_on_insert}
    logic          flg_we, pos_we, nxt_we;
    logic [IW-1:0] flg_waddr, pos_waddr, nxt_waddr;
    logic [1:0]    flg_wdata, flg_q;
    logic [P-1:0]  pos_wdata, pos_q;
    logic [IW:0]   nxt_wdata, nxt_q;
    logic [IW-1:0] slot_raddr, nxt_raddr;

    mpt_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_flags_ram (
        .i_clk   (i_clk),
        .i_we    (flg_we),
        .i_waddr (flg_waddr),
        .i_wdata (flg_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (flg_q)
    );

    mpt_ram #(.WIDTH(P), .DEPTH(SLOTS)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (pos_q)
    );

    mpt_ram #(.WIDTH(IW+1), .DEPTH(SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (nxt_raddr),
        .o_rdata (nxt_q)
    );

    logic req_fire;
    logic out_free;
    logic slot_used;   // used bit of the addressed single slot (exec state)
    logic walk_used;   // used bit of the slot coming back in the walk
    logic [IW-1:0] alloc_slot;
    logic [P-1:0]  walk_new;
    logic          walk_chg;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // Slots at or above the fresh mark were never allocated: read them as free.
    assign slot_used  = r_idx_ok && ({1'b0, r_idx} < r_fresh) && flg_q[1];
    assign walk_used  = ({1'b0, r_rd_idx} < r_fresh) && flg_q[1];
    assign alloc_slot = r_free_head[IW-1:0];

    // Per-slot adjust rule on the word that just came back from memory.
    always_comb begin
        walk_new = pos_q;
        walk_chg = 1'b0;
        if (r_mode == MODE_ADJ_INSERT) begin
            if (pos_q == r_p1) begin
                if (flg_q[0] || r_before) begin
                    walk_new = r_p2;
                    walk_chg = 1'b1;
                end
            end else if (pos_q > r_p1) begin
                walk_new = add_sat(pos_q, r_delta);
                walk_chg = 1'b1;
            end
        end else begin
            if ({1'b0, pos_q} >= r_old_end) begin
                walk_new = add_sat(pos_q, r_delta);
                walk_chg = 1'b1;
            end else if (pos_q > r_p1) begin
                walk_new = r_p1;
                walk_chg = 1'b1;
            end
        end
    end

    // Next state, memory control and bookkeeping.
    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_fresh      = r_fresh;
        n_highest    = r_highest;
        n_delta      = r_delta;
        n_old_end    = r_old_end;
        n_addr       = r_addr;
        n_res_slot   = r_res_slot;
        n_res_pos    = r_res_pos;
        n_res_status = r_res_status;

        flg_we    = 1'b0;
        flg_waddr = r_idx;
        flg_wdata = 2'b00;
        pos_we    = 1'b0;
        pos_waddr = r_idx;
        pos_wdata = r_p1;
        nxt_we    = 1'b0;
        nxt_waddr = r_idx;
        nxt_wdata = r_free_head;

        slot_raddr = IW'(i_req.slot_index);
        nxt_raddr  = r_free_head[IW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res_slot   = r_slot_in;
                n_res_pos    = '0;
                n_res_status = STAT_OK;
                n_state      = ST_DONE;
                case (r_mode)
                    MODE_ADD: begin
                        if (r_free_head >= SLOTS_END) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            // Fresh slots link to the next slot up.
                            n_free_head = (r_free_head < r_fresh) ? nxt_q
                                                                  : r_free_head + 1'b1;
                            if (r_free_head == r_fresh) begin
                                n_fresh = r_fresh + 1'b1;
                            end
                            if (alloc_slot > r_highest) begin
                                n_highest = alloc_slot;
                            end
                            flg_we     = 1'b1;
                            flg_waddr  = alloc_slot;
                            flg_wdata  = {1'b1, r_adv};
                            n_res_slot = SLOT_W'(alloc_slot);
                        end
                    end
                    MODE_REMOVE: begin
                        if (!slot_used) begin
                            n_res_status = STAT_NOT_USED;
                        end else begin
                            nxt_we      = 1'b1;
                            n_free_head = {1'b0, r_idx};
                            flg_we      = 1'b1;
                            n_res_pos   = POS_W'(pos_q);
                        end
                    end
                    MODE_SET_POS: begin
                        if (!slot_used) begin
                            n_res_status = STAT_NOT_USED;
                        end else begin
                            pos_we = 1'b1;
                        end
                    end
                    MODE_GET_POS: begin
                        if (!slot_used) begin
                            n_res_status = STAT_NOT_USED;
                        end else begin
                            n_res_pos = POS_W'(pos_q);
                        end
                    end
                    MODE_ADJ_INSERT: begin
                        n_delta = {1'b0, r_p2} - {1'b0, r_p1};
                        n_addr  = '0;
                        n_state = ST_WALK;
                    end
                    MODE_ADJ_REPLACE: begin
                        n_delta   = {1'b0, r_nl} - {1'b0, r_p2};
                        n_old_end = {1'b0, r_p1} + {1'b0, r_p2};
                        n_addr    = '0;
                        n_state   = ST_WALK;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_WALK, ST_DRAIN: begin
                // Issue the read of the next slot, write back the one returned.
                slot_raddr = r_addr;
                if (r_rd_valid && walk_used && walk_chg) begin
                    pos_we    = 1'b1;
                    pos_waddr = r_rd_idx;
                    pos_wdata = walk_new;
                end
                if (r_state == ST_WALK) begin
                    if (r_addr == r_highest) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_highest   <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_highest   <= n_highest;
            r_rd_valid  <= (r_state == ST_WALK);
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_mode    <= t_mode'(i_req.mode);
            r_slot_in <= i_req.slot_index;
            r_idx     <= IW'(i_req.slot_index);
            r_idx_ok  <= (32'(i_req.slot_index) < 32'(SLOTS));
            r_adv     <= i_req.advance_on_insert;
            r_before  <= i_req.advance_all;
            r_p1      <= clamp_in(i_req.first_pos);
            r_p2      <= clamp_in(i_req.second_pos);
            r_nl      <= clamp_in(i_req.new_length);
        end
        r_delta      <= n_delta;
        r_old_end    <= n_old_end;
        r_addr       <= n_addr;
        r_rd_idx     <= r_addr;
        r_res_slot   <= n_res_slot;
        r_res_pos    <= n_res_pos;
        r_res_status <= n_res_status;
        if (r_state == ST_DONE && out_free) begin
            r_out_slot   <= r_res_slot;
            r_out_pos    <= r_res_pos;
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_slot = r_out_slot;
    assign o_rsp.result_pos  = r_out_pos;
    assign o_rsp.status      = r_out_status;

    // ---- assertions ----
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_addr <= r_highest))
        else $error("walk address ran past highest used slot");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= SLOTS_END)
        else $error("free-list head out of range");

    a_fresh_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fresh == '0) || ({1'b0, r_highest} < r_fresh))
        else $error("highest used slot beyond fresh mark");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter exec");

    a_walk_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> r_rd_valid)
        else $error("drain without pending read");
endmodule
